FILE: src/frops_pkg.sv
// Package for the fragment raster output stage: register indexes, compare and
// blend factor codes, and the compare and factor select functions.
// No dependencies.
package frops_pkg;

    localparam int DEPTH_BITS_DEFAULT = 24;
    localparam int DEPTH_W            = 24;
    localparam int COLOR_W            = 8;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 8;
    localparam int SUM_W              = 17;
    localparam int NUM_CH             = 4;
    localparam int ALPHA_CH           = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_FUNC  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_WRITE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_FACTOR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_FACTOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_FUNC  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_REF   = 3'd5;

    // compare codes
    localparam logic [3:0] CMP_NEVER    = 4'd0;
    localparam logic [3:0] CMP_LESS     = 4'd1;
    localparam logic [3:0] CMP_EQUAL    = 4'd2;
    localparam logic [3:0] CMP_LEQUAL   = 4'd3;
    localparam logic [3:0] CMP_GREATER  = 4'd4;
    localparam logic [3:0] CMP_NOTEQUAL = 4'd5;
    localparam logic [3:0] CMP_GEQUAL   = 4'd6;
    localparam logic [3:0] CMP_ALWAYS   = 4'd7;
    localparam logic [3:0] CMP_DISABLED = 4'd8;

    // blend factor codes
    localparam logic [3:0] BF_ZERO          = 4'd0;
    localparam logic [3:0] BF_ONE           = 4'd1;
    localparam logic [3:0] BF_SRC_COLOR     = 4'd2;
    localparam logic [3:0] BF_INV_SRC_COLOR = 4'd3;
    localparam logic [3:0] BF_DST_COLOR     = 4'd4;
    localparam logic [3:0] BF_INV_DST_COLOR = 4'd5;
    localparam logic [3:0] BF_SRC_ALPHA     = 4'd6;
    localparam logic [3:0] BF_INV_SRC_ALPHA = 4'd7;
    localparam logic [3:0] BF_DST_ALPHA     = 4'd8;
    localparam logic [3:0] BF_INV_DST_ALPHA = 4'd9;
    localparam logic [3:0] BF_SATURATE      = 4'd10;

    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

    localparam logic [3:0] RST_DEPTH_FUNC  = CMP_LESS;
    localparam logic       RST_DEPTH_WRITE = 1'b1;
    localparam logic [3:0] RST_SRC_FACTOR  = BF_ONE;
    localparam logic [3:0] RST_DST_FACTOR  = BF_ZERO;
    localparam logic [2:0] RST_ALPHA_FUNC  = 3'(CMP_ALWAYS);
    localparam logic [7:0] RST_ALPHA_REF   = 8'd0;

    // a op b given a<b and a==b
    function automatic logic cmp_pass(input logic [3:0] code, input logic lt,
                                      input logic eq);
        logic r;
        case (code)
            CMP_LESS:     r = lt;
            CMP_EQUAL:    r = eq;
            CMP_LEQUAL:   r = lt | eq;
            CMP_GREATER:  r = ~(lt | eq);
            CMP_NOTEQUAL: r = ~eq;
            CMP_GEQUAL:   r = ~lt;
            CMP_ALWAYS:   r = 1'b1;
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] blend_factor(
        input logic [3:0]         code,
        input logic               is_alpha,
        input logic [COLOR_W-1:0] s_ch,
        input logic [COLOR_W-1:0] d_ch,
        input logic [COLOR_W-1:0] s_a,
        input logic [COLOR_W-1:0] d_a
    );
        logic [COLOR_W-1:0] f;
        logic [COLOR_W-1:0] inv_da;
        inv_da = COLOR_MAX - d_a;
        case (code)
            BF_ZERO:          f = '0;
            BF_ONE:           f = COLOR_MAX;
            BF_SRC_COLOR:     f = s_ch;
            BF_INV_SRC_COLOR: f = COLOR_MAX - s_ch;
            BF_DST_COLOR:     f = d_ch;
            BF_INV_DST_COLOR: f = COLOR_MAX - d_ch;
            BF_SRC_ALPHA:     f = s_a;
            BF_INV_SRC_ALPHA: f = COLOR_MAX - s_a;
            BF_DST_ALPHA:     f = d_a;
            BF_INV_DST_ALPHA: f = inv_da;
            BF_SATURATE:      f = is_alpha ? COLOR_MAX : ((s_a < inv_da) ? s_a : inv_da);
            default:          f = '0;
        endcase
        return f;
    endfunction

endpackage

FILE: src/fragment_raster_ops.sv
// Fragment raster output stage: each accepted input beat becomes an output beat
// via the stage registers; throughput one fragment per cycle, stalls propagate per stage.
// Stages: depth test and factor select, multiply-add, divide by 255 with
// saturate, alpha test into the output register.
// Reset (async, active low) restores config defaults and empties the pipe.
// Depends on frops_pkg.
module fragment_raster_ops #(
    parameter int DEPTH_BITS = frops_pkg::DEPTH_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [frops_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [frops_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [frops_pkg::COLOR_W-1:0]       src_red,
    input  logic [frops_pkg::COLOR_W-1:0]       src_green,
    input  logic [frops_pkg::COLOR_W-1:0]       src_blue,
    input  logic [frops_pkg::COLOR_W-1:0]       src_alpha,
    input  logic [frops_pkg::DEPTH_W-1:0]       frag_depth,
    input  logic [frops_pkg::DEPTH_W-1:0]       stored_depth,
    input  logic [frops_pkg::COLOR_W-1:0]       dst_red,
    input  logic [frops_pkg::COLOR_W-1:0]       dst_green,
    input  logic [frops_pkg::COLOR_W-1:0]       dst_blue,
    input  logic [frops_pkg::COLOR_W-1:0]       dst_alpha,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                depth_we,
    output logic [frops_pkg::DEPTH_W-1:0]       depth_out,
    output logic                                color_we,
    output logic [frops_pkg::COLOR_W-1:0]       out_red,
    output logic [frops_pkg::COLOR_W-1:0]       out_green,
    output logic [frops_pkg::COLOR_W-1:0]       out_blue,
    output logic [frops_pkg::COLOR_W-1:0]       out_alpha
);

    localparam int DW = frops_pkg::DEPTH_W;
    localparam int CW = frops_pkg::COLOR_W;
    localparam int SW = frops_pkg::SUM_W;
    localparam int NCH = frops_pkg::NUM_CH;
    localparam int CMP_BITS = (DEPTH_BITS < DW) ? DEPTH_BITS : DW;
    localparam logic [DW-1:0] CMP_MASK = (DW'(1) << CMP_BITS) - DW'(1);

    // config registers
    logic [3:0]    depth_func_reg;
    logic          depth_write_reg;
    logic [3:0]    src_factor_reg;
    logic [3:0]    dst_factor_reg;
    logic [2:0]    alpha_func_reg;
    logic [CW-1:0] alpha_ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_func_reg  <= frops_pkg::RST_DEPTH_FUNC;
            depth_write_reg <= frops_pkg::RST_DEPTH_WRITE;
            src_factor_reg  <= frops_pkg::RST_SRC_FACTOR;
            dst_factor_reg  <= frops_pkg::RST_DST_FACTOR;
            alpha_func_reg  <= frops_pkg::RST_ALPHA_FUNC;
            alpha_ref_reg   <= frops_pkg::RST_ALPHA_REF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                frops_pkg::REG_DEPTH_FUNC:  depth_func_reg  <= cfg_data[3:0];
                frops_pkg::REG_DEPTH_WRITE: depth_write_reg <= cfg_data[0];
                frops_pkg::REG_SRC_FACTOR:  src_factor_reg  <= cfg_data[3:0];
                frops_pkg::REG_DST_FACTOR:  dst_factor_reg  <= cfg_data[3:0];
                frops_pkg::REG_ALPHA_FUNC:  alpha_func_reg  <= cfg_data[2:0];
                frops_pkg::REG_ALPHA_REF:   alpha_ref_reg   <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // per-stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

    assign s4_rdy   = !s4_valid_reg || !out_stall;
    assign s3_rdy   = !s3_valid_reg || s4_rdy;
    assign s2_rdy   = !s2_valid_reg || s3_rdy;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_stall = !s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy) s1_valid_reg <= in_valid;
            if (s2_rdy) s2_valid_reg <= s1_valid_reg;
            if (s3_rdy) s3_valid_reg <= s2_valid_reg;
            if (s4_rdy) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: depth test, factor select
    logic [CW-1:0] src_ch [NCH];
    logic [CW-1:0] dst_ch [NCH];
    logic [DW-1:0] fdep, sdep;
    logic          dpass_next, dwe_next;
    logic [CW-1:0] sf_next [NCH];
    logic [CW-1:0] df_next [NCH];

    assign src_ch[0] = src_red;
    assign src_ch[1] = src_green;
    assign src_ch[2] = src_blue;
    assign src_ch[3] = src_alpha;
    assign dst_ch[0] = dst_red;
    assign dst_ch[1] = dst_green;
    assign dst_ch[2] = dst_blue;
    assign dst_ch[3] = dst_alpha;
    assign fdep = frag_depth & CMP_MASK;
    assign sdep = stored_depth & CMP_MASK;

    always_comb
    begin
        if (depth_func_reg == frops_pkg::CMP_DISABLED)
        begin
            dpass_next = 1'b1;
            dwe_next   = 1'b0;
        end
        else
        begin
            dpass_next = frops_pkg::cmp_pass(depth_func_reg, fdep < sdep, fdep == sdep);
            dwe_next   = dpass_next && depth_write_reg;
        end
        for (int i = 0; i < NCH; i++)
        begin
            sf_next[i] = frops_pkg::blend_factor(src_factor_reg, i == frops_pkg::ALPHA_CH,
                src_ch[i], dst_ch[i], src_alpha, dst_alpha);
            df_next[i] = frops_pkg::blend_factor(dst_factor_reg, i == frops_pkg::ALPHA_CH,
                src_ch[i], dst_ch[i], src_alpha, dst_alpha);
        end
    end

    logic          s1_pass_reg, s1_dwe_reg;
    logic [DW-1:0] s1_depth_reg;
    logic [CW-1:0] s1_src_reg [NCH];
    logic [CW-1:0] s1_dst_reg [NCH];
    logic [CW-1:0] s1_sf_reg  [NCH];
    logic [CW-1:0] s1_df_reg  [NCH];

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_pass_reg  <= dpass_next;
            s1_dwe_reg   <= dwe_next;
            s1_depth_reg <= fdep;
            for (int i = 0; i < NCH; i++)
            begin
                s1_src_reg[i] <= src_ch[i];
                s1_dst_reg[i] <= dst_ch[i];
                s1_sf_reg[i]  <= sf_next[i];
                s1_df_reg[i]  <= df_next[i];
            end
        end
    end

    // stage 2: sf*s + df*d
    logic [SW-1:0] sum_next [NCH];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            sum_next[i] = SW'(s1_sf_reg[i]) * SW'(s1_src_reg[i])
                        + SW'(s1_df_reg[i]) * SW'(s1_dst_reg[i]);
        end
    end

    logic          s2_pass_reg, s2_dwe_reg;
    logic [DW-1:0] s2_depth_reg;
    logic [SW-1:0] s2_sum_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (s2_rdy)
        begin
            s2_pass_reg  <= s1_pass_reg;
            s2_dwe_reg   <= s1_dwe_reg;
            s2_depth_reg <= s1_depth_reg;
            for (int i = 0; i < NCH; i++)
            begin
                s2_sum_reg[i] <= sum_next[i];
            end
        end
    end

    // stage 3: floor(x/255) as (x*257)>>16 plus one correction, then saturate
    logic [SW+8:0] recip_prod [NCH];
    logic [9:0]    q0 [NCH];
    logic [SW:0]   rem [NCH];
    logic [9:0]    q [NCH];
    logic [CW-1:0] color_next [NCH];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            recip_prod[i] = {s2_sum_reg[i], 8'd0} + (SW+9)'(s2_sum_reg[i]);
            q0[i]  = recip_prod[i][SW+8:16];
            rem[i] = {1'b0, s2_sum_reg[i]} - (({8'd0, q0[i]} << 8) - {8'd0, q0[i]});
            q[i]   = q0[i] + ((rem[i] >= (SW+1)'(frops_pkg::COLOR_MAX)) ? 10'd1 : 10'd0);
            color_next[i] = (q[i] > 10'(frops_pkg::COLOR_MAX)) ? frops_pkg::COLOR_MAX
                                                               : q[i][CW-1:0];
        end
    end

    logic          s3_pass_reg, s3_dwe_reg;
    logic [DW-1:0] s3_depth_reg;
    logic [CW-1:0] s3_color_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (s3_rdy)
        begin
            s3_pass_reg  <= s2_pass_reg;
            s3_dwe_reg   <= s2_dwe_reg;
            s3_depth_reg <= s2_depth_reg;
            for (int i = 0; i < NCH; i++)
            begin
                s3_color_reg[i] <= color_next[i];
            end
        end
    end

    // stage 4: alpha test, output register
    logic          cwe_next;
    logic [CW-1:0] a3;

    assign a3 = s3_color_reg[frops_pkg::ALPHA_CH];
    assign cwe_next = s3_pass_reg
        && frops_pkg::cmp_pass({1'b0, alpha_func_reg}, a3 < alpha_ref_reg, a3 == alpha_ref_reg);

    logic          s4_dwe_reg, s4_cwe_reg;
    logic [DW-1:0] s4_depth_reg;
    logic [CW-1:0] s4_color_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (s4_rdy)
        begin
            s4_dwe_reg   <= s3_dwe_reg;
            s4_cwe_reg   <= cwe_next;
            s4_depth_reg <= s3_dwe_reg ? s3_depth_reg : '0;
            for (int i = 0; i < NCH; i++)
            begin
                s4_color_reg[i] <= s3_pass_reg ? s3_color_reg[i] : '0;
            end
        end
    end

    assign out_valid = s4_valid_reg;
    assign depth_we  = s4_dwe_reg;
    assign depth_out = s4_depth_reg;
    assign color_we  = s4_cwe_reg;
    assign out_red   = s4_color_reg[0];
    assign out_green = s4_color_reg[1];
    assign out_blue  = s4_color_reg[2];
    assign out_alpha = s4_color_reg[3];

endmodule
